@@ src/udt_pkg.sv @@
// udt_pkg: shared types, codes and constants of the udp socket demux table
// used by udt_entry_ram, udt_seq, udp_socket_demux_table and udt_checker
package udt_pkg;

	localparam int ADDR_W = 32;
	localparam int PORT_W = 16;
	localparam int LEN_W = 16;
	localparam int SLOT_W = 4;
	localparam int STATUS_W = 3;
	localparam int CMD_W = 2;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_INDEX_W = 1;

	localparam int DEFAULT_TABLE_ENTRIES = 16;

	localparam logic [PORT_W-1:0] RESET_PORT = 16'd1024;
	localparam logic [PORT_W-1:0] LAST_PORT = 16'hFFFF;
	localparam logic [LEN_W-1:0] HEADER_BYTES = 16'd8;

	// commands
	localparam logic [CMD_W-1:0] CMD_RECEIVE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_CONNECT = 2'd1;
	localparam logic [CMD_W-1:0] CMD_LISTEN = 2'd2;
	localparam logic [CMD_W-1:0] CMD_DISCONNECT = 2'd3;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NOMATCH = 3'd1;
	localparam logic [STATUS_W-1:0] ST_SHORT = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FULL = 3'd3;
	localparam logic [STATUS_W-1:0] ST_BADSLOT = 3'd4;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_LOCAL_ADDRESS = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_FIRST_PORT = 1'd1;

	// one table entry as stored in the ram
	typedef struct packed {
		logic [ADDR_W-1:0] local_address;
		logic [PORT_W-1:0] local_port;
		logic [ADDR_W-1:0] remote_address;
		logic [PORT_W-1:0] remote_port;
		logic listening;
	} entry_t;

	// one result handed from the sequencer to the output register
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SLOT_W-1:0] slot;
		logic [LEN_W-1:0] payload_length;
		logic [PORT_W-1:0] assigned_port;
	} result_t;

endpackage

@@ src/udp_socket_demux_table.sv @@
// A compact UDP endpoint table: connect and listen append an entry, disconnect
// moves the last entry into the freed slot, and a received packet header is
// matched against the entries from slot 0 upward, the first hit winning. Each
// request gives exactly one result. The entries live in a single-port-write,
// registered-read ram; a receive reads one entry per cycle with the compare in
// the cycle after the read, and every result passes through the output
// register. A disconnect reads the last entry, then writes it into the freed
// slot. Requests are handled one at a time; a finished result waits in the
// output register while the next request is taken.
// Configuration writes are taken any time and should be issued while idle.
// depends on udt_pkg, udt_seq and udt_entry_ram
module udp_socket_demux_table #(
	parameter int TABLE_ENTRIES = udt_pkg::DEFAULT_TABLE_ENTRIES
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_write,
	input logic [udt_pkg::CFG_INDEX_W-1:0] cfg_index,
	input logic [udt_pkg::CFG_DATA_W-1:0] cfg_data,
	input logic in_valid,
	output logic in_ready,
	input logic [udt_pkg::CMD_W-1:0] command,
	input logic [udt_pkg::ADDR_W-1:0] source_address,
	input logic [udt_pkg::ADDR_W-1:0] destination_address,
	input logic [udt_pkg::PORT_W-1:0] source_port,
	input logic [udt_pkg::PORT_W-1:0] destination_port,
	input logic [udt_pkg::LEN_W-1:0] packet_length,
	input logic [udt_pkg::SLOT_W-1:0] slot_index,
	output logic out_valid,
	input logic out_ready,
	output logic [udt_pkg::STATUS_W-1:0] status,
	output logic [udt_pkg::SLOT_W-1:0] matched_slot,
	output logic [udt_pkg::LEN_W-1:0] payload_length,
	output logic [udt_pkg::PORT_W-1:0] assigned_port
);

	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	logic [udt_pkg::ADDR_W-1:0] local_address_q;
	logic [udt_pkg::PORT_W-1:0] first_port_q;
	logic out_valid_q;
	udt_pkg::result_t out_q;

	logic res_valid;
	logic res_ready;
	udt_pkg::result_t res;
	logic mem_wr_en;
	logic [IW-1:0] mem_wr_addr;
	udt_pkg::entry_t mem_wr_data;
	logic mem_rd_en;
	logic [IW-1:0] mem_rd_addr;
	udt_pkg::entry_t mem_rd_data;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_address_q <= '0;
			first_port_q <= udt_pkg::RESET_PORT;
		end else if (cfg_write) begin
			case (cfg_index)
				udt_pkg::REG_LOCAL_ADDRESS: local_address_q <= cfg_data;
				udt_pkg::REG_FIRST_PORT: first_port_q <= cfg_data[udt_pkg::PORT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	udt_seq #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.CW(CW),
		.IW(IW)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.source_address(source_address),
		.destination_address(destination_address),
		.source_port(source_port),
		.destination_port(destination_port),
		.packet_length(packet_length),
		.slot_index(slot_index),
		.local_address(local_address_q),
		.first_port(first_port_q),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res),
		.mem_wr_en(mem_wr_en),
		.mem_wr_addr(mem_wr_addr),
		.mem_wr_data(mem_wr_data),
		.mem_rd_en(mem_rd_en),
		.mem_rd_addr(mem_rd_addr),
		.mem_rd_data(mem_rd_data)
	);

	udt_entry_ram #(
		.DEPTH(TABLE_ENTRIES),
		.IW(IW)
	) u_ram (
		.clk(clk),
		.wr_en(mem_wr_en),
		.wr_addr(mem_wr_addr),
		.wr_data(mem_wr_data),
		.rd_en(mem_rd_en),
		.rd_addr(mem_rd_addr),
		.rd_data(mem_rd_data)
	);

	// output register
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign status = out_q.status;
	assign matched_slot = out_q.slot;
	assign payload_length = out_q.payload_length;
	assign assigned_port = out_q.assigned_port;

endmodule

@@ src/udt_entry_ram.sv @@
// udt_entry_ram: single write port, single read port entry memory, registered read
// depends on udt_pkg for the entry type
module udt_entry_ram #(
	parameter int DEPTH = udt_pkg::DEFAULT_TABLE_ENTRIES,
	parameter int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input logic clk,
	input logic wr_en,
	input logic [IW-1:0] wr_addr,
	input udt_pkg::entry_t wr_data,
	input logic rd_en,
	input logic [IW-1:0] rd_addr,
	output udt_pkg::entry_t rd_data
);

	udt_pkg::entry_t mem_q [DEPTH];
	udt_pkg::entry_t rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ src/udt_seq.sv @@
// udt_seq: command sequencer, table scan, entry count and local port counter
// depends on udt_pkg; drives the ports of udt_entry_ram
module udt_seq #(
	parameter int TABLE_ENTRIES = udt_pkg::DEFAULT_TABLE_ENTRIES,
	parameter int CW = $clog2(TABLE_ENTRIES + 1),
	parameter int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [udt_pkg::CMD_W-1:0] command,
	input logic [udt_pkg::ADDR_W-1:0] source_address,
	input logic [udt_pkg::ADDR_W-1:0] destination_address,
	input logic [udt_pkg::PORT_W-1:0] source_port,
	input logic [udt_pkg::PORT_W-1:0] destination_port,
	input logic [udt_pkg::LEN_W-1:0] packet_length,
	input logic [udt_pkg::SLOT_W-1:0] slot_index,
	input logic [udt_pkg::ADDR_W-1:0] local_address,
	input logic [udt_pkg::PORT_W-1:0] first_port,
	output logic res_valid,
	input logic res_ready,
	output udt_pkg::result_t res,
	output logic mem_wr_en,
	output logic [IW-1:0] mem_wr_addr,
	output udt_pkg::entry_t mem_wr_data,
	output logic mem_rd_en,
	output logic [IW-1:0] mem_rd_addr,
	input udt_pkg::entry_t mem_rd_data
);

	localparam int SW = (CW > udt_pkg::SLOT_W) ? CW : udt_pkg::SLOT_W;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_MOVE = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	logic [1:0] state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic [udt_pkg::PORT_W-1:0] next_port_q, next_port_d;
	logic [CW-1:0] iss_q, iss_d;
	logic cmp_v_s1;
	logic [CW-1:0] cmp_idx_s1;
	udt_pkg::result_t res_q, res_d;

	// request fields kept for the scan and the move
	logic [udt_pkg::ADDR_W-1:0] src_addr_q;
	logic [udt_pkg::ADDR_W-1:0] dst_addr_q;
	logic [udt_pkg::PORT_W-1:0] src_port_q;
	logic [udt_pkg::PORT_W-1:0] dst_port_q;
	logic [udt_pkg::LEN_W-1:0] len_q;
	logic [udt_pkg::SLOT_W-1:0] slot_q;

	logic accept;
	logic table_full;
	logic bad_slot;
	logic [SW-1:0] count_ext;
	logic [SW-1:0] cmp_idx_ext;
	logic local_hit;
	logic remote_hit;
	logic [CW-1:0] last_idx;
	udt_pkg::entry_t new_entry;
	udt_pkg::entry_t latched_entry;

	assign in_ready = (state_q == S_IDLE);
	assign accept = in_valid && in_ready;
	assign res_valid = (state_q == S_DONE);
	assign res = res_q;

	assign table_full = (count_q == CW'(TABLE_ENTRIES));
	assign count_ext = SW'(count_q);
	assign cmp_idx_ext = SW'(cmp_idx_s1);
	assign bad_slot = (SW'(slot_index) >= count_ext);
	assign last_idx = count_q - CW'(1);

	// compare the entry read in the previous cycle
	assign local_hit = (mem_rd_data.local_address == dst_addr_q) &&
		(mem_rd_data.local_port == dst_port_q);
	assign remote_hit = (mem_rd_data.remote_address == src_addr_q) &&
		(mem_rd_data.remote_port == src_port_q);

	// entry built by connect or listen
	always_comb begin
		new_entry.local_address = local_address;
		if (command == udt_pkg::CMD_LISTEN) begin
			new_entry.local_port = source_port;
			new_entry.remote_address = '0;
			new_entry.remote_port = '0;
			new_entry.listening = 1'b1;
		end else begin
			new_entry.local_port = next_port_q;
			new_entry.remote_address = source_address;
			new_entry.remote_port = source_port;
			new_entry.listening = 1'b0;
		end
	end

	// listening entry after it latches the remote endpoint
	always_comb begin
		latched_entry = mem_rd_data;
		latched_entry.remote_address = src_addr_q;
		latched_entry.remote_port = src_port_q;
		latched_entry.listening = 1'b0;
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		count_d = count_q;
		next_port_d = next_port_q;
		iss_d = iss_q;
		res_d = res_q;
		mem_wr_en = 1'b0;
		mem_wr_addr = IW'(count_q);
		mem_wr_data = new_entry;
		mem_rd_en = 1'b0;
		mem_rd_addr = IW'(iss_q);
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					res_d = '0;
					state_d = S_DONE;
					case (command)
						udt_pkg::CMD_RECEIVE: begin
							if (packet_length < udt_pkg::HEADER_BYTES) begin
								res_d.status = udt_pkg::ST_SHORT;
							end else if (count_q == '0) begin
								res_d.status = udt_pkg::ST_NOMATCH;
							end else begin
								iss_d = '0;
								state_d = S_SCAN;
							end
						end
						udt_pkg::CMD_CONNECT, udt_pkg::CMD_LISTEN: begin
							if (table_full) begin
								res_d.status = udt_pkg::ST_FULL;
							end else begin
								mem_wr_en = 1'b1;
								count_d = count_q + CW'(1);
								res_d.status = udt_pkg::ST_OK;
								res_d.slot = count_ext[udt_pkg::SLOT_W-1:0];
								if (command == udt_pkg::CMD_CONNECT) begin
									res_d.assigned_port = next_port_q;
									if (next_port_q == udt_pkg::LAST_PORT) begin
										next_port_d = first_port;
									end else begin
										next_port_d = next_port_q + 16'd1;
									end
								end
							end
						end
						default: begin
							if (bad_slot) begin
								res_d.status = udt_pkg::ST_BADSLOT;
							end else begin
								// fetch the last entry to move into the freed slot
								mem_rd_en = 1'b1;
								mem_rd_addr = IW'(last_idx);
								state_d = S_MOVE;
							end
						end
					endcase
				end
			end
			S_SCAN: begin
				// issue one read a cycle while comparing the previous one
				if (iss_q < count_q) begin
					mem_rd_en = 1'b1;
					iss_d = iss_q + CW'(1);
				end
				if (cmp_v_s1) begin
					if (local_hit && mem_rd_data.listening) begin
						mem_wr_en = 1'b1;
						mem_wr_addr = IW'(cmp_idx_s1);
						mem_wr_data = latched_entry;
						res_d.status = udt_pkg::ST_OK;
						res_d.slot = cmp_idx_ext[udt_pkg::SLOT_W-1:0];
						res_d.payload_length = len_q - udt_pkg::HEADER_BYTES;
						state_d = S_DONE;
					end else if (local_hit && remote_hit) begin
						res_d.status = udt_pkg::ST_OK;
						res_d.slot = cmp_idx_ext[udt_pkg::SLOT_W-1:0];
						res_d.payload_length = len_q - udt_pkg::HEADER_BYTES;
						state_d = S_DONE;
					end else if (cmp_idx_s1 == last_idx) begin
						res_d.status = udt_pkg::ST_NOMATCH;
						state_d = S_DONE;
					end
				end
			end
			S_MOVE: begin
				mem_wr_en = 1'b1;
				mem_wr_addr = IW'(slot_q);
				mem_wr_data = mem_rd_data;
				count_d = last_idx;
				res_d.status = udt_pkg::ST_OK;
				res_d.slot = slot_q;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			next_port_q <= udt_pkg::RESET_PORT;
			iss_q <= '0;
			cmp_v_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			next_port_q <= next_port_d;
			iss_q <= iss_d;
			cmp_v_s1 <= (state_q == S_SCAN) && mem_rd_en;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		res_q <= res_d;
		cmp_idx_s1 <= iss_q;
		if (accept) begin
			src_addr_q <= source_address;
			dst_addr_q <= destination_address;
			src_port_q <= source_port;
			dst_port_q <= destination_port;
			len_q <= packet_length;
			slot_q <= slot_index;
		end
	end

endmodule

@@ src/udt_checker.sv @@
// udt_checker: port-level assertions for udp_socket_demux_table, bound to the top level
// depends on udt_pkg for the status codes
module udt_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [udt_pkg::STATUS_W-1:0] status,
	input logic [udt_pkg::SLOT_W-1:0] matched_slot,
	input logic [udt_pkg::LEN_W-1:0] payload_length,
	input logic [udt_pkg::PORT_W-1:0] assigned_port
);

	// a stalled result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) &&
		$stable(matched_slot) && $stable(payload_length) && $stable(assigned_port))
		else $error("result changed while stalled");

	// one request at a time: ready drops after an accepted request
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while one is in progress");

	// rejected requests carry no slot, length or port
	a_reject_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != udt_pkg::ST_OK |->
		matched_slot == '0 && payload_length == '0 && assigned_port == '0)
		else $error("rejected result carries data");

	// status stays within the defined codes
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == udt_pkg::ST_OK || status == udt_pkg::ST_NOMATCH ||
		status == udt_pkg::ST_SHORT || status == udt_pkg::ST_FULL ||
		status == udt_pkg::ST_BADSLOT)
		else $error("undefined status code");

endmodule

bind udp_socket_demux_table udt_checker u_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_ready(in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.status(status),
	.matched_slot(matched_slot),
	.payload_length(payload_length),
	.assigned_port(assigned_port)
);
